// ----- hdl/rpnc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN calculator package
// Opcodes, status codes and the structures passed between the controller,
// the datapath and the arithmetic unit.
// ----------------------------------------------------------------------------
package rpnc_pkg;

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_POP  = 4'd1;
  localparam logic [3:0] OP_ADD  = 4'd2;
  localparam logic [3:0] OP_SUB  = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd5;
  localparam logic [3:0] OP_LOAD = 4'd6;
  localparam logic [3:0] OP_ACC  = 4'd7;
  localparam logic [3:0] OP_CMP  = 4'd8;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_FEW  = 3'd2;
  localparam logic [2:0] ST_DIVZ = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic take;
    logic rd_top;
    logic rd_below;
    logic cap_top;
    logic cap_below;
    logic start_arith;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_read;
    logic is_bin;
    logic arith_done;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic done;
    logic sat;
    logic divz;
  } arith_stat_t;

endpackage

// ----- hdl/stack_calculator_with_register.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack calculator with working register
// Q16.16 RPN stack calculator: controller, datapath and arithmetic unit.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  opcode, operand
//   out_     output     out_valid/out_stall register_value, stack_depth,
//                                          status, equal
//   cfg_     input      cfg_write_en       capacity (cfg_write_data)
//
// One command is in flight at a time. Load, accumulate, compare and push go
// from decode to commit; pop first reads the top entry; add, sub, mul and div
// read two entries and run the arithmetic unit, whose divide makes one bit per
// cycle of a 48-bit quotient; a failed entry-count check skips to commit.
// Reset is synchronous and clears the register, depth and capacity (to 128).
// A stalled result is held in the output register while the next command runs;
// that command then waits in its commit cycle until the register is free.
// ----------------------------------------------------------------------------
module stack_calculator_with_register #(
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [31:0] in_operand,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_register_value,
  output logic [7:0]  out_stack_depth,
  output logic [2:0]  out_status,
  output logic        out_equal
);

  rpnc_pkg::ctl_cmd_t cmd;
  rpnc_pkg::dp_stat_t stat;

  rpnc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpnc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_operand         (in_operand),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_register_value (out_register_value),
    .out_stack_depth    (out_stack_depth),
    .out_status         (out_status),
    .out_equal          (out_equal)
  );

endmodule

// ----- hdl/rpnc_arith.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN calculator arithmetic unit
// Saturating Q16.16 add, subtract, multiply and a bit-serial restoring divide.
// ----------------------------------------------------------------------------
module rpnc_arith (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [3:0]           op,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  output logic [31:0]          res,
  output rpnc_pkg::arith_stat_t ast
);

  typedef enum logic [2:0] {AR_IDLE, AR_MUL, AR_DIV, AR_DSAT, AR_FIN} ar_state_t;

  ar_state_t          state_r;
  logic [31:0]        res_r;
  logic               sat_r;
  logic               divz_r;
  logic signed [63:0] prod_r;
  logic [47:0]        q_r;
  logic [31:0]        rem_r;
  logic [31:0]        dsr_r;
  logic               neg_r;
  logic [5:0]         cnt_r;

  logic [32:0] sum_w;
  logic [32:0] rem_sh_w;
  logic        ge_w;
  logic [63:0] sh_w;
  logic [31:0] mag_a_w;
  logic [31:0] mag_b_w;

  assign sum_w    = (op == rpnc_pkg::OP_SUB) ? ({a[31], a} - {b[31], b})
                                             : ({a[31], a} + {b[31], b});
  assign rem_sh_w = {rem_r, q_r[47]};
  assign ge_w     = rem_sh_w >= {1'b0, dsr_r};
  assign sh_w     = 64'(prod_r >>> 16);
  assign mag_a_w  = a[31] ? (32'd0 - a) : a;
  assign mag_b_w  = b[31] ? (32'd0 - b) : b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AR_IDLE;
      sat_r   <= 1'b0;
      divz_r  <= 1'b0;
    end else begin
      case (state_r)
        AR_IDLE: begin
          if (start) begin
            sat_r  <= 1'b0;
            divz_r <= 1'b0;
            if (op == rpnc_pkg::OP_MUL) begin
              prod_r  <= $signed(a) * $signed(b);
              state_r <= AR_MUL;
            end else if (op == rpnc_pkg::OP_DIV) begin
              if (b == 32'd0) begin
                divz_r  <= 1'b1;
                state_r <= AR_FIN;
              end else begin
                neg_r   <= a[31] ^ b[31];
                q_r     <= {mag_a_w, 16'd0};
                rem_r   <= 32'd0;
                dsr_r   <= mag_b_w;
                cnt_r   <= 6'd47;
                state_r <= AR_DIV;
              end
            end else begin
              if (sum_w[32] != sum_w[31]) begin
                sat_r <= 1'b1;
                res_r <= sum_w[32] ? rpnc_pkg::Q_MIN : rpnc_pkg::Q_MAX;
              end else begin
                res_r <= sum_w[31:0];
              end
              state_r <= AR_FIN;
            end
          end
        end
        AR_MUL: begin
          if (sh_w[63:31] != {33{1'b0}} && sh_w[63:31] != {33{1'b1}}) begin
            sat_r <= 1'b1;
            res_r <= sh_w[63] ? rpnc_pkg::Q_MIN : rpnc_pkg::Q_MAX;
          end else begin
            res_r <= sh_w[31:0];
          end
          state_r <= AR_FIN;
        end
        AR_DIV: begin
          rem_r <= ge_w ? 32'(rem_sh_w - {1'b0, dsr_r}) : rem_sh_w[31:0];
          q_r   <= {q_r[46:0], ge_w};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_r <= AR_DSAT;
          end
        end
        AR_DSAT: begin
          if (neg_r) begin
            if (q_r[47:32] != 16'd0 || (q_r[31] && q_r[30:0] != 31'd0)) begin
              sat_r <= 1'b1;
              res_r <= rpnc_pkg::Q_MIN;
            end else begin
              res_r <= 32'd0 - q_r[31:0];
            end
          end else begin
            if (q_r[47:31] != 17'd0) begin
              sat_r <= 1'b1;
              res_r <= rpnc_pkg::Q_MAX;
            end else begin
              res_r <= q_r[31:0];
            end
          end
          state_r <= AR_FIN;
        end
        AR_FIN: begin
          state_r <= AR_IDLE;
        end
        default: begin
          state_r <= AR_IDLE;
        end
      endcase
    end
  end

  assign res      = res_r;
  assign ast.done = (state_r == AR_FIN);
  assign ast.sat  = sat_r;
  assign ast.divz = divz_r;

endmodule

// ----- hdl/rpnc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN calculator controller
// Sequences stack reads, arithmetic and the final commit of each command.
// ----------------------------------------------------------------------------
module rpnc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpnc_pkg::dp_stat_t  stat,
  output rpnc_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_TOP, S_BELOW, S_START, S_WAIT, S_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.need_read) begin
          cmd.rd_top = 1'b1;
          state_nxt  = S_TOP;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_TOP: begin
        cmd.cap_top = 1'b1;
        if (stat.is_bin) begin
          cmd.rd_below = 1'b1;
          state_nxt    = S_BELOW;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_BELOW: begin
        cmd.cap_below = 1'b1;
        state_nxt     = S_START;
      end
      S_START: begin
        cmd.start_arith = 1'b1;
        state_nxt       = S_WAIT;
      end
      S_WAIT: begin
        if (stat.arith_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- hdl/rpnc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN calculator datapath
// Stack memory, working register, depth counter, capacity and result register.
// ----------------------------------------------------------------------------
module rpnc_dp #(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpnc_pkg::ctl_cmd_t cmd,
  output rpnc_pkg::dp_stat_t stat,
  input  logic [3:0]         in_opcode,
  input  logic [31:0]        in_operand,
  input  logic               cfg_write_en,
  input  logic [7:0]         cfg_write_data,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [31:0]        out_register_value,
  output logic [7:0]         out_stack_depth,
  output logic [2:0]         out_status,
  output logic               out_equal
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data_r;
  logic [3:0]  op_r;
  logic [31:0] operand_r;
  logic [7:0]  cap_r;
  logic [7:0]  depth_r;
  logic [7:0]  depth_nxt;
  logic [31:0] reg_r;
  logic [31:0] reg_nxt;
  logic [31:0] top_r;
  logic [31:0] below_r;
  logic        out_valid_r;
  logic [31:0] out_reg_r;
  logic [7:0]  out_depth_r;
  logic [2:0]  out_status_r;
  logic        out_eq_r;

  logic [2:0]  status_w;
  logic        eq_w;
  logic        wr_en_w;
  logic [AW-1:0] wr_addr_w;
  logic [31:0] wr_data_w;
  logic [AW-1:0] rd_addr_w;
  logic        is_push_w;
  logic        is_pop_w;
  logic        is_bin_w;
  logic        full_w;
  logic        few_w;
  logic [32:0] acc_w;
  logic [31:0] ar_res_w;
  rpnc_pkg::arith_stat_t ast_w;

  rpnc_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start_arith),
    .op    (op_r),
    .a     (below_r),
    .b     (top_r),
    .res   (ar_res_w),
    .ast   (ast_w)
  );

  assign is_push_w = (op_r == rpnc_pkg::OP_PUSH);
  assign is_pop_w  = (op_r == rpnc_pkg::OP_POP);
  assign is_bin_w  = (op_r == rpnc_pkg::OP_ADD) || (op_r == rpnc_pkg::OP_SUB) ||
                     (op_r == rpnc_pkg::OP_MUL) || (op_r == rpnc_pkg::OP_DIV);
  assign full_w    = (cap_r == 8'd0 && depth_r != 8'd0) ||
                     (cap_r != 8'd0 && depth_r >= cap_r) ||
                     (32'(depth_r) >= 32'(STACK_DEPTH));
  assign few_w     = is_pop_w ? (depth_r == 8'd0) : (depth_r < 8'd2);
  assign acc_w     = {reg_r[31], reg_r} + {operand_r[31], operand_r};
  assign rd_addr_w = cmd.rd_top ? AW'(depth_r - 8'd1) : AW'(depth_r - 8'd2);

  always_comb begin
    reg_nxt   = reg_r;
    depth_nxt = depth_r;
    status_w  = rpnc_pkg::ST_OK;
    eq_w      = 1'b0;
    wr_en_w   = 1'b0;
    wr_addr_w = AW'(depth_r);
    wr_data_w = reg_r;
    case (op_r)
      rpnc_pkg::OP_PUSH: begin
        if (full_w) begin
          status_w = rpnc_pkg::ST_FULL;
        end else begin
          wr_en_w   = cmd.commit;
          depth_nxt = depth_r + 8'd1;
        end
      end
      rpnc_pkg::OP_POP: begin
        if (few_w) begin
          status_w = rpnc_pkg::ST_FEW;
        end else begin
          reg_nxt   = top_r;
          depth_nxt = depth_r - 8'd1;
        end
      end
      rpnc_pkg::OP_ADD, rpnc_pkg::OP_SUB, rpnc_pkg::OP_MUL, rpnc_pkg::OP_DIV: begin
        if (few_w) begin
          status_w = rpnc_pkg::ST_FEW;
        end else if (ast_w.divz) begin
          status_w = rpnc_pkg::ST_DIVZ;
        end else begin
          wr_en_w   = cmd.commit;
          wr_addr_w = AW'(depth_r - 8'd2);
          wr_data_w = ar_res_w;
          reg_nxt   = ar_res_w;
          depth_nxt = depth_r - 8'd1;
          status_w  = ast_w.sat ? rpnc_pkg::ST_SAT : rpnc_pkg::ST_OK;
        end
      end
      rpnc_pkg::OP_LOAD: begin
        reg_nxt = operand_r;
      end
      rpnc_pkg::OP_ACC: begin
        if (acc_w[32] != acc_w[31]) begin
          reg_nxt  = acc_w[32] ? rpnc_pkg::Q_MIN : rpnc_pkg::Q_MAX;
          status_w = rpnc_pkg::ST_SAT;
        end else begin
          reg_nxt = acc_w[31:0];
        end
      end
      rpnc_pkg::OP_CMP: begin
        eq_w = (reg_r == operand_r);
      end
      default: begin
        reg_nxt = reg_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en_w) begin
      mem[wr_addr_w] <= wr_data_w;
    end
    if (cmd.rd_top || cmd.rd_below) begin
      rd_data_r <= mem[rd_addr_w];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r      <= in_opcode;
      operand_r <= in_operand;
    end
    if (cmd.cap_top) begin
      top_r <= rd_data_r;
    end
    if (cmd.cap_below) begin
      below_r <= rd_data_r;
    end
    if (cmd.commit) begin
      out_reg_r    <= reg_nxt;
      out_depth_r  <= depth_nxt;
      out_status_r <= status_w;
      out_eq_r     <= eq_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= 8'd128;
      depth_r     <= 8'd0;
      reg_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        cap_r <= cfg_write_data;
      end
      if (cmd.commit) begin
        depth_r <= depth_nxt;
        reg_r   <= reg_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.need_read  = (is_pop_w || is_bin_w) && !few_w;
  assign stat.is_bin     = is_bin_w;
  assign stat.arith_done = ast_w.done;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_register_value = out_reg_r;
  assign out_stack_depth    = out_depth_r;
  assign out_status         = out_status_r;
  assign out_equal          = out_eq_r;

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("Commit while the result register still holds a transaction.");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_push_w && !full_w) |=> (depth_r == $past(depth_r) + 8'd1))
    else $error("Successful push did not raise the depth by one.");

  a_error_keeps_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (status_w == rpnc_pkg::ST_FULL || status_w == rpnc_pkg::ST_FEW ||
                    status_w == rpnc_pkg::ST_DIVZ))
    |=> ($stable(reg_r) && $stable(depth_r)))
    else $error("A failed command changed the register or the depth.");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack calculator testbench
// Drives commands through the valid/stall input channel, predicts every result
// with a Q16.16 stack model of its own and checks each output transaction
// field by field, under random sender gaps and receiver stalls, at several capacities.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH = 128;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] reg_value;
    logic [7:0]  depth;
    logic [2:0]  status;
    logic        equal;
  } calc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_opcode = '0;
  logic [31:0] in_operand = '0;
  logic        cfg_write_en = 1'b0;
  logic [7:0]  cfg_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_register_value;
  logic [7:0]  out_stack_depth;
  logic [2:0]  out_status;
  logic        out_equal;

  logic [31:0]  shadow_stack [DEPTH];
  int unsigned  shadow_depth;
  logic [31:0]  shadow_reg;
  int unsigned  shadow_cap;
  calc_result_t expected_results [$];
  int           errors = 0;
  int           cycles = 0;
  int           hold_off = 0;
  bit           gaps_on = 1'b1;

  always #5 clk = ~clk;

  stack_calculator_with_register #(.STACK_DEPTH(DEPTH)) u_top (.*);

  function automatic logic [31:0] saturate(input logic signed [65:0] v, inout bit sat);
    if (v > 66'sh7FFF_FFFF) begin
      sat = 1'b1;
      return rpnc_pkg::Q_MAX;
    end
    if (v < -66'sh8000_0000) begin
      sat = 1'b1;
      return rpnc_pkg::Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic calc_result_t compute_command(input logic [3:0] op, input logic [31:0] arg);
    calc_result_t r;
    logic signed [65:0] top, below, wide;
    logic [31:0] res;
    bit sat;
    int unsigned cap;
    r = '0;
    sat = 1'b0;
    cap = (shadow_cap == 0) ? 1 : (shadow_cap > DEPTH ? DEPTH : shadow_cap);
    case (op)
      rpnc_pkg::OP_PUSH: begin
        if (shadow_depth >= cap) r.status = rpnc_pkg::ST_FULL;
        else begin
          shadow_stack[shadow_depth] = shadow_reg;
          shadow_depth++;
        end
      end
      rpnc_pkg::OP_POP: begin
        if (shadow_depth == 0) r.status = rpnc_pkg::ST_FEW;
        else begin
          shadow_depth--;
          shadow_reg = shadow_stack[shadow_depth];
        end
      end
      rpnc_pkg::OP_ADD, rpnc_pkg::OP_SUB, rpnc_pkg::OP_MUL, rpnc_pkg::OP_DIV: begin
        if (shadow_depth < 2) r.status = rpnc_pkg::ST_FEW;
        else begin
          top = 66'(signed'(shadow_stack[shadow_depth-1]));
          below = 66'(signed'(shadow_stack[shadow_depth-2]));
          if (op == rpnc_pkg::OP_DIV && top == 0) r.status = rpnc_pkg::ST_DIVZ;
          else begin
            case (op)
              rpnc_pkg::OP_ADD: wide = below + top;
              rpnc_pkg::OP_SUB: wide = below - top;
              rpnc_pkg::OP_MUL: wide = (below * top) >>> 16;
              default: wide = (below * 66'sd65536) / top;
            endcase
            res = saturate(wide, sat);
            shadow_depth--;
            shadow_stack[shadow_depth-1] = res;
            shadow_reg = res;
          end
        end
      end
      rpnc_pkg::OP_LOAD: shadow_reg = arg;
      rpnc_pkg::OP_ACC:
        shadow_reg = saturate(66'(signed'(shadow_reg)) + 66'(signed'(arg)), sat);
      rpnc_pkg::OP_CMP: r.equal = (shadow_reg == arg);
      default: ;
    endcase
    if (sat && r.status == rpnc_pkg::ST_OK) r.status = rpnc_pkg::ST_SAT;
    r.reg_value = shadow_reg;
    r.depth = shadow_depth[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (gaps_on) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    calc_result_t got, exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_register_value, out_stack_depth, out_status, out_equal};
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: register_value %h", got.reg_value);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.reg_value !== exp_r.reg_value) begin
          $error("register_value: expected %h, actual %h", exp_r.reg_value, got.reg_value);
          errors++;
        end
        if (got.depth !== exp_r.depth) begin
          $error("stack_depth: expected %0d, actual %0d", exp_r.depth, got.depth);
          errors++;
        end
        if (got.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, got.status);
          errors++;
        end
        if (got.equal !== exp_r.equal) begin
          $error("equal: expected %0d, actual %0d", exp_r.equal, got.equal);
          errors++;
        end
      end
    end
  end

  task automatic send_command(input logic [3:0] op, input logic [31:0] arg);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_operand <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(compute_command(op, arg));
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    release_input();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [7:0] value);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    shadow_cap = 32'(value);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return rpnc_pkg::Q_MAX;
      1: return rpnc_pkg::Q_MIN;
      2: return 32'($urandom_range(0, 8) - 4) << 16;
      3: return 32'($urandom_range(0, 200) - 100);
      4: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? 32'hFFFF_0000 : 32'h0);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_command(rpnc_pkg::OP_POP, 0);
    send_command(rpnc_pkg::OP_ADD, 0);
    send_command(rpnc_pkg::OP_LOAD, rpnc_pkg::Q_MAX);
    send_command(rpnc_pkg::OP_PUSH, 0);
    send_command(rpnc_pkg::OP_CMP, rpnc_pkg::Q_MAX);
    send_command(rpnc_pkg::OP_CMP, 0);
    send_command(rpnc_pkg::OP_ACC, 32'h0001_0000);
    send_command(rpnc_pkg::OP_PUSH, 0);
    send_command(rpnc_pkg::OP_ADD, 0);
    send_command(rpnc_pkg::OP_LOAD, rpnc_pkg::Q_MIN);
    send_command(rpnc_pkg::OP_ACC, rpnc_pkg::Q_MIN);
    send_command(rpnc_pkg::OP_PUSH, 0);
    send_command(rpnc_pkg::OP_MUL, 0);
    send_command(rpnc_pkg::OP_LOAD, 0);
    send_command(rpnc_pkg::OP_PUSH, 0);
    send_command(rpnc_pkg::OP_DIV, 0);
    send_command(rpnc_pkg::OP_SUB, 0);
    send_command(rpnc_pkg::OP_POP, 0);
    send_command(4'd9, 32'hFFFF_FFFF);
    send_command(4'd15, 0);
    send_command(rpnc_pkg::OP_LOAD, 32'h0003_0000);
    send_command(rpnc_pkg::OP_PUSH, 0);
    send_command(rpnc_pkg::OP_DIV, 0);
    send_command(rpnc_pkg::OP_POP, 0);
    send_command(rpnc_pkg::OP_POP, 0);
  endtask

  task automatic test_capacity_limits();
    set_capacity(8'd1);
    repeat (3) send_command(rpnc_pkg::OP_PUSH, 0);
    set_capacity(8'd0);
    repeat (2) send_command(rpnc_pkg::OP_PUSH, 0);
    set_capacity(8'd255);
    repeat (DEPTH + 2) send_command(rpnc_pkg::OP_PUSH, 0);
    set_capacity(8'd3);
    send_command(rpnc_pkg::OP_PUSH, 0);
    repeat (DEPTH + 1) send_command(rpnc_pkg::OP_POP, 0);
  endtask

  task automatic test_random(input int count, input logic [7:0] cap);
    logic [3:0] op;
    set_capacity(cap);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: op = rpnc_pkg::OP_PUSH;
        2: op = rpnc_pkg::OP_POP;
        3: op = rpnc_pkg::OP_ADD;
        4: op = rpnc_pkg::OP_SUB;
        5: op = rpnc_pkg::OP_MUL;
        6: op = rpnc_pkg::OP_DIV;
        7: op = rpnc_pkg::OP_LOAD;
        8: op = rpnc_pkg::OP_ACC;
        default:
          op = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : rpnc_pkg::OP_CMP;
      endcase
      send_command(op, (op == rpnc_pkg::OP_CMP && $urandom_range(0, 1)) ? shadow_reg
                                                                        : rand_value());
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_off = 400;
    for (int i = 0; i < 20; i++)
      send_command(i[0] ? rpnc_pkg::OP_ACC : rpnc_pkg::OP_LOAD, rand_value());
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    test_random(150, 8'd128);
    gaps_on = 1'b1;
  endtask

  initial begin
    shadow_depth = 0;
    shadow_reg = '0;
    shadow_cap = 128;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity_limits();
    test_random(350, 8'd128);
    test_random(400, 8'd4);
    test_random(400, 8'd40);
    test_backpressure();
    test_no_gaps();
    test_random(300, 8'd2);
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
